@@ hw/rtl/fpace_pkg.sv @@
package fpace_pkg;

    // Widths of the time values and the configuration fields.
    localparam int TIME_W      = 32;
    localparam int SLOT_W      = 6;
    localparam int SPEED_W     = 4;
    localparam int THRESH_W    = 8;
    localparam int SKIPS_W     = 4;
    localparam int PERIOD_W    = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // Reset values of registers and state.
    localparam logic [THRESH_W-1:0] THRESH_RESET   = 8'd10;
    localparam logic [SKIPS_W-1:0]  SKIPS_RESET    = 4'd4;
    localparam logic [TIME_W-1:0]   DRAW_TIME_INIT = 32'd1000;

    // Slave-side beat layout.
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 2;

    // Master-side beat layout, from the lowest bit up.
    localparam int M_GRANTED_BIT = 0;
    localparam int M_SKIP_BIT    = 1;
    localparam int M_FORCED_BIT  = 2;
    localparam int M_WAIT_LO     = 3;
    localparam int M_FRAMES_LO   = M_WAIT_LO + TIME_W;
    localparam int M_SKIPS_LO    = M_FRAMES_LO + TIME_W;
    localparam int M_ELAPSED_LO  = M_SKIPS_LO + TIME_W;
    localparam int M_USED_W      = M_ELAPSED_LO + TIME_W;
    localparam int M_DATA_W      = ((M_USED_W + 7) / 8) * 8;

    // Event commands.
    typedef enum logic [1:0] {
        CMD_SYNC        = 2'd0,
        CMD_CHECK       = 2'd1,
        CMD_SKIP_QUERY  = 2'd2,
        CMD_UPDATE_DONE = 2'd3
    } t_cmd;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SKIPS   = 2'd2;

    // Base frame period of a slot: the 8-slot pattern 16,16,15,16,15,16,16,15.
    function automatic logic [PERIOD_W-1:0] f_base_period(input logic [2:0] slot);
        logic [PERIOD_W-1:0] p;
        case (slot)
            3'd2, 3'd4, 3'd7: p = 5'd15;
            default:          p = 5'd16;
        endcase
        return p;
    endfunction

endpackage

@@ hw/rtl/frame_pacer_with_skip_control.sv @@
// Path: an accepted slave beat goes through the input register, then the result register,
// to become its master beat, and waits longer while the master side stalls.
// Throughput: one event per cycle while the master side takes results; all state updates
// are adds and compares done between the input register and the result register.
// Reset (i_rst_n low, synchronous): both stages empty, registers back to their defaults,
// counters and timing state cleared, last draw time set to 1000 ms.
module frame_pacer_with_skip_control
    import fpace_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave side.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,   // [31:0] now_ms
    input  logic [S_USER_W-1:0]   s_axis_tuser,   // [1:0] command
    // Master side.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] granted, [1] skip, [2] forced_update, [34:3] wait_ms, [66:35] frame_count,
    // [98:67] skip_count, [130:99] elapsed_ms, [135:131] zero
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [SPEED_W-1:0]  r_timer_speed;
    logic [THRESH_W-1:0] r_sleep_thresh;
    logic [SKIPS_W-1:0]  r_max_skips;

    // Pacer state.
    logic [TIME_W-1:0]   r_last_tick, n_last_tick;
    logic [TIME_W-1:0]   r_carried, n_carried;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [TIME_W-1:0]   r_frames, n_frames;
    logic [TIME_W-1:0]   r_skipped, n_skipped;
    logic [TIME_W-1:0]   r_elapsed, n_elapsed;
    logic [TIME_W-1:0]   r_draw_time, n_draw_time;
    logic [TIME_W-1:0]   r_draw_start, n_draw_start;
    logic [SKIPS_W-1:0]  r_skip_run, n_skip_run;

    // Input register.
    logic                r_in_valid;
    t_cmd                r_cmd;
    logic [TIME_W-1:0]   r_now;

    // Result register.
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;

    logic                advance;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   diff;
    logic [TIME_W+1:0]   off;
    logic [TIME_W:0]     rest;
    logic                grant_ok;
    logic [TIME_W+1:0]   skip_rhs;
    logic                late;
    logic [SKIPS_W:0]    run;
    logic                n_granted, n_skip, n_forced;
    logic [TIME_W-1:0]   n_wait;

    // The stage moves on when the result register is free or is being emptied.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    // Shared arithmetic: period, offset against the period, lateness test.
    assign period   = f_base_period(r_slot[2:0]) - {1'b0, r_timer_speed};
    assign diff     = r_carried + r_now - r_last_tick;
    assign off      = {{2{diff[TIME_W-1]}}, diff} - {{(TIME_W+2-PERIOD_W){1'b0}}, period};
    assign rest     = off[TIME_W+1] ? TIME_W'(0) - off[TIME_W:0] : off[TIME_W:0];
    assign grant_ok = !off[TIME_W+1] || (rest <= {{(TIME_W+1-THRESH_W){1'b0}}, r_sleep_thresh});
    assign skip_rhs = {{2{r_draw_time[TIME_W-1]}}, r_draw_time}
                    + {{(TIME_W+2-PERIOD_W){1'b0}}, period};
    assign late     = $signed({{2{r_carried[TIME_W-1]}}, r_carried}) > $signed(skip_rhs);
    assign run      = {1'b0, r_skip_run} + {{SKIPS_W{1'b0}}, 1'b1};

    // Event processing.
    always_comb begin
        n_last_tick  = r_last_tick;
        n_carried    = r_carried;
        n_slot       = r_slot;
        n_frames     = r_frames;
        n_skipped    = r_skipped;
        n_elapsed    = r_elapsed;
        n_draw_time  = r_draw_time;
        n_draw_start = r_draw_start;
        n_skip_run   = r_skip_run;
        n_granted    = 1'b0;
        n_skip       = 1'b0;
        n_forced     = 1'b0;
        n_wait       = '0;
        unique case (r_cmd)
            CMD_SYNC: begin
                n_last_tick = r_now;
                n_carried   = '0;
            end
            CMD_CHECK: begin
                if (grant_ok) begin
                    n_carried   = off[TIME_W-1:0];
                    n_frames    = r_frames + 1'b1;
                    n_slot      = r_slot + 1'b1;
                    n_elapsed   = r_elapsed + (r_now - r_last_tick);
                    n_last_tick = r_now;
                    n_granted   = 1'b1;
                end else begin
                    n_wait = rest[TIME_W-1:0];
                end
            end
            CMD_SKIP_QUERY: begin
                n_draw_start = r_now;
                if (late) begin
                    if (run > {1'b0, r_max_skips}) begin
                        n_skip_run = '0;
                        n_forced   = 1'b1;
                    end else begin
                        n_skip_run = run[SKIPS_W-1:0];
                        n_skipped  = r_skipped + 1'b1;
                        n_skip     = 1'b1;
                    end
                end else begin
                    n_skip_run = '0;
                end
            end
            CMD_UPDATE_DONE: begin
                n_draw_time = r_now - r_draw_start;
            end
            default: begin
                n_skip_run = r_skip_run;
            end
        endcase
        n_out_data = {{(M_DATA_W-M_USED_W){1'b0}}, n_elapsed, n_skipped, n_frames,
                      n_wait, n_forced, n_skip, n_granted};
    end

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_speed  <= '0;
            r_sleep_thresh <= THRESH_RESET;
            r_max_skips    <= SKIPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TIMER_SPEED:  r_timer_speed  <= i_cfg_data[SPEED_W-1:0];
                REG_SLEEP_THRESH: r_sleep_thresh <= i_cfg_data[THRESH_W-1:0];
                REG_MAX_SKIPS:    r_max_skips    <= i_cfg_data[SKIPS_W-1:0];
                default:          r_max_skips    <= r_max_skips;
            endcase
        end
    end

    // Pipeline control and pacer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_tick  <= '0;
            r_carried    <= '0;
            r_slot       <= '0;
            r_frames     <= '0;
            r_skipped    <= '0;
            r_elapsed    <= '0;
            r_draw_time  <= DRAW_TIME_INIT;
            r_draw_start <= '0;
            r_skip_run   <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_last_tick  <= n_last_tick;
                r_carried    <= n_carried;
                r_slot       <= n_slot;
                r_frames     <= n_frames;
                r_skipped    <= n_skipped;
                r_elapsed    <= n_elapsed;
                r_draw_time  <= n_draw_time;
                r_draw_start <= n_draw_start;
                r_skip_run   <= n_skip_run;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_cmd <= t_cmd'(s_axis_tuser);
            r_now <= s_axis_tdata;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

@@ hw/rtl/fpace_checker.sv @@
module fpace_checker
    import fpace_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_DATA_W-1:0]   m_axis_tdata
);

    // A stalled master beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("master beat changed while stalled");

    // An accepted event reaches the master side via both stage registers if unstalled.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("event result missing after two cycles");

    // Only one of granted, skip and forced update is ever reported.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $countones(m_axis_tdata[M_FORCED_BIT:M_GRANTED_BIT]) <= 1)
        else $error("more than one outcome flag set");

    // A granted frame reports no wait.
    a_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[M_GRANTED_BIT]
            |-> m_axis_tdata[M_FRAMES_LO-1:M_WAIT_LO] == '0)
        else $error("wait reported on a granted frame");

endmodule

bind frame_pacer_with_skip_control fpace_checker u_fpace_checker (.*);
